// ===== design/ipv4p_pkg.sv =====
// Shared types and constants for the IPv4 dotted address parser.
// Used by the front classifier, the class queue and the back sequencer.
`default_nettype none

package ipv4p_pkg;

   // Default depth of the queue between the front and the back part.
   localparam int QUEUE_DEPTH = 2;

   // Character codes that the classifier looks for.
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_DOT    = 8'h2e;
   localparam logic [7:0] CHAR_LOW_X  = 8'h78;
   localparam logic [7:0] CHAR_HIGH_X = 8'h58;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_NUL    = 8'h00;

   // Range limits of the last part, by the number of dots seen.
   localparam logic [31:0] LIMIT_ONE_DOT    = 32'h00ff_ffff;
   localparam logic [31:0] LIMIT_TWO_DOTS   = 32'h0000_ffff;
   localparam logic [31:0] LIMIT_THREE_DOTS = 32'h0000_00ff;

   // Class of one character, as the back part needs it.
   typedef enum logic [2:0] {
      KIND_DIGIT      = 3'd0,
      KIND_HEX_LETTER = 3'd1,
      KIND_X          = 3'd2,
      KIND_DOT        = 3'd3,
      KIND_SPACE      = 3'd4,
      KIND_TERM       = 3'd5,
      KIND_OTHER      = 3'd6
   } char_kind_type;

   // One classified character: its kind and its digit value.
   typedef struct packed {
      char_kind_type kind;
      logic [3:0]    value;
   } char_class_type;

   // Head of the queue as the back part sees it.
   typedef struct packed {
      logic           valid;
      char_class_type entry;
   } queue_head_type;

endpackage

`default_nettype wire

// ===== design/ipv4p_front.sv =====
// Front part of the IPv4 dotted address parser: classifies each request byte.
// Depends on ipv4p_pkg for the class types and character codes.
`default_nettype none

module ipv4p_front (
   input  wire logic [7:0]               req_tdata,
   output ipv4p_pkg::char_class_type     entry
);

   // Sort the byte into the kinds the sequencer acts on.
   always_comb begin
      entry.value = req_tdata[3:0];
      if (req_tdata == ipv4p_pkg::CHAR_NUL) begin
         entry.kind = ipv4p_pkg::KIND_TERM;
      end else if (req_tdata inside {[ipv4p_pkg::CHAR_ZERO:ipv4p_pkg::CHAR_NINE]}) begin
         entry.kind = ipv4p_pkg::KIND_DIGIT;
      end else if (req_tdata inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         // Letters a to f and A to F carry low nibbles 1 to 6.
         entry.kind  = ipv4p_pkg::KIND_HEX_LETTER;
         entry.value = req_tdata[3:0] + 4'd9;
      end else if (req_tdata == ipv4p_pkg::CHAR_LOW_X ||
                   req_tdata == ipv4p_pkg::CHAR_HIGH_X) begin
         entry.kind = ipv4p_pkg::KIND_X;
      end else if (req_tdata == ipv4p_pkg::CHAR_DOT) begin
         entry.kind = ipv4p_pkg::KIND_DOT;
      end else if (req_tdata inside {ipv4p_pkg::CHAR_SPACE, [8'h09:8'h0d]}) begin
         entry.kind = ipv4p_pkg::KIND_SPACE;
      end else begin
         entry.kind = ipv4p_pkg::KIND_OTHER;
      end
   end

endmodule

`default_nettype wire

// ===== design/ipv4p_queue.sv =====
// Short queue of classified characters between the front and back parts.
// Depends on ipv4p_pkg for the entry and head types.
`default_nettype none

module ipv4p_queue #(
   parameter int DEPTH = ipv4p_pkg::QUEUE_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push_valid,
   output logic                           push_ready,
   input  wire ipv4p_pkg::char_class_type push_entry,
   output ipv4p_pkg::queue_head_type      head,
   input  wire logic                      pop
);

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   ipv4p_pkg::char_class_type slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.entry = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ===== design/ipv4p_back.sv =====
// Back part of the IPv4 dotted address parser: the per-character sequencer,
// the saved parts and the result register. Depends on ipv4p_pkg.
`default_nettype none

module ipv4p_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ipv4p_pkg::queue_head_type head,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic                           rsp_valid_res,
   output logic [31:0]                    rsp_address
);

   typedef enum logic [4:0] {
      PH_START  = 5'b00001,
      PH_ZERO   = 5'b00010,
      PH_DIGITS = 5'b00100,
      PH_DONE   = 5'b01000,
      PH_ERROR  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_OCT = 2'd1,
      RADIX_HEX = 2'd2
   } radix_type;

   phase_type   phase_ff, phase_in;
   radix_type   radix_ff, radix_in;
   logic [31:0] acc_ff,   acc_in;
   logic [1:0]  dots_ff,  dots_in;
   logic [23:0] saved_ff [3];
   logic        save_en;

   logic        out_valid_ff, out_valid_in;
   logic        out_ok_ff,    out_ok_in;
   logic [31:0] out_addr_ff,  out_addr_in;

   logic        out_free;
   logic        is_term;
   logic        load_result;
   radix_type   eff_radix;
   logic [31:0] scaled;
   logic [31:0] digit_sum;
   logic [31:0] merged;
   logic        in_range;
   logic        fin_ok;

   ipv4p_pkg::char_kind_type kind;
   logic [3:0]               value;

   assign kind     = head.entry.kind;
   assign value    = head.entry.value;
   assign out_free = !out_valid_ff || rsp_tready;
   assign is_term  = (kind == ipv4p_pkg::KIND_TERM);

   // A terminator waits until the result register can take its result.
   assign pop         = head.valid && (!is_term || out_free);
   assign load_result = head.valid && is_term && out_free;

   // Scaling of the accumulator by the radix, as shifts and one add.
   assign eff_radix = (phase_ff == PH_ZERO) ? RADIX_OCT : radix_ff;
   always_comb begin
      case (eff_radix)
         RADIX_HEX: scaled = {acc_ff[27:0], 4'b0};
         RADIX_OCT: scaled = {acc_ff[28:0], 3'b0};
         default:   scaled = {acc_ff[28:0], 3'b0} + {acc_ff[30:0], 1'b0};
      endcase
   end
   assign digit_sum = scaled + {28'b0, value};

   // Merge the saved parts with the last part and range check it.
   always_comb begin
      case (dots_ff)
         2'd1: begin
            in_range = (acc_ff <= ipv4p_pkg::LIMIT_ONE_DOT);
            merged   = acc_ff | {saved_ff[0][7:0], 24'b0};
         end
         2'd2: begin
            in_range = (acc_ff <= ipv4p_pkg::LIMIT_TWO_DOTS);
            merged   = acc_ff | {saved_ff[0][7:0], 24'b0} | {saved_ff[1][15:0], 16'b0};
         end
         2'd3: begin
            in_range = (acc_ff <= ipv4p_pkg::LIMIT_THREE_DOTS);
            merged   = acc_ff | {saved_ff[0][7:0], 24'b0} | {saved_ff[1][15:0], 16'b0}
                       | {saved_ff[2], 8'b0};
         end
         default: begin
            in_range = 1'b1;
            merged   = acc_ff;
         end
      endcase
   end
   assign fin_ok = in_range && (phase_ff != PH_START) && (phase_ff != PH_ERROR);

   // Sequencer: next text state for the character at the queue head.
   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      acc_in   = acc_ff;
      dots_in  = dots_ff;
      save_en  = 1'b0;
      if (pop) begin
         if (is_term) begin
            phase_in = PH_START;
            radix_in = RADIX_DEC;
            acc_in   = '0;
            dots_in  = '0;
         end else begin
            case (phase_ff)
               PH_START: begin
                  if (kind == ipv4p_pkg::KIND_DIGIT && value == 4'd0) begin
                     phase_in = PH_ZERO;
                     radix_in = RADIX_OCT;
                     acc_in   = '0;
                  end else if (kind == ipv4p_pkg::KIND_DIGIT) begin
                     phase_in = PH_DIGITS;
                     radix_in = RADIX_DEC;
                     acc_in   = {28'b0, value};
                  end else begin
                     phase_in = PH_ERROR;
                  end
               end
               PH_ZERO, PH_DIGITS: begin
                  if (phase_ff == PH_ZERO && kind == ipv4p_pkg::KIND_X) begin
                     radix_in = RADIX_HEX;
                     phase_in = PH_DIGITS;
                  end else begin
                     radix_in = eff_radix;
                     phase_in = PH_DIGITS;
                     case (kind)
                        ipv4p_pkg::KIND_DIGIT: begin
                           acc_in = digit_sum;
                        end
                        ipv4p_pkg::KIND_HEX_LETTER: begin
                           if (eff_radix == RADIX_HEX) begin
                              acc_in = digit_sum;
                           end else begin
                              phase_in = PH_ERROR;
                           end
                        end
                        ipv4p_pkg::KIND_DOT: begin
                           if (dots_ff == 2'd3) begin
                              phase_in = PH_ERROR;
                           end else begin
                              save_en  = 1'b1;
                              dots_in  = dots_ff + 1'b1;
                              phase_in = PH_START;
                              radix_in = RADIX_DEC;
                              acc_in   = '0;
                           end
                        end
                        ipv4p_pkg::KIND_SPACE: begin
                           phase_in = PH_DONE;
                        end
                        default: begin
                           phase_in = PH_ERROR;
                        end
                     endcase
                  end
               end
               default: begin
                  // Finished or failed text: bytes are ignored.
               end
            endcase
         end
      end
   end

   // Result register: loaded by a terminator, cleared once taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_ok_in    = out_ok_ff;
      out_addr_in  = out_addr_ff;
      if (load_result) begin
         out_valid_in = 1'b1;
         out_ok_in    = fin_ok;
         out_addr_in  = fin_ok ? merged : '0;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         radix_ff     <= RADIX_DEC;
         acc_ff       <= '0;
         dots_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         radix_ff     <= radix_in;
         acc_ff       <= acc_in;
         dots_ff      <= dots_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Saved parts and result payload need no reset.
   always_ff @(posedge clock) begin
      if (save_en) begin
         saved_ff[dots_ff] <= acc_ff[23:0];
      end
      out_ok_ff   <= out_ok_in;
      out_addr_ff <= out_addr_in;
   end

   assign rsp_tvalid    = out_valid_ff;
   assign rsp_valid_res = out_ok_ff;
   assign rsp_address   = out_addr_ff;

endmodule

`default_nettype wire

// ===== design/ipv4_dotted_address_parser.sv =====
// Top level of the IPv4 dotted address parser: front classifier, class queue
// and back sequencer. Depends on ipv4p_pkg and the ipv4p_* modules.
//
//   Channel  Direction  Payload (lowest bit first)
//   req_     in         tdata[7:0] character
//   rsp_     out        tdata[0] valid_res, tdata[32:1] address, tdata[39:33] zero
//
// One character is taken per cycle while the queue has room; the sequencer takes
// one queue entry per cycle unless a terminator waits for the result register, so
// the rate is one request per clock while results are taken. A result is registered
// once its terminating zero byte reaches the queue head.
// A terminator waits in the queue while the result register holds a result
// that has not been taken; characters behind it wait in the queue, and the
// input stalls once the queue is full.
// Synchronous reset clears the queue, the sequencer and the result valid flag.
`default_nettype none

module ipv4_dotted_address_parser #(
   parameter int QUEUE_DEPTH = ipv4p_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] character
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [0] valid_res, [32:1] address, [39:33] zero
);

   ipv4p_pkg::char_class_type entry;
   ipv4p_pkg::queue_head_type head;
   logic                      pop;
   logic                      valid_res;
   logic [31:0]               address;

   // Classify the incoming character.
   ipv4p_front u_front (
      .req_tdata (req_tdata),
      .entry     (entry)
   );

   // Decouple the classifier from the sequencer.
   ipv4p_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_entry (entry),
      .head       (head),
      .pop        (pop)
   );

   // Run the parse and hold the result.
   ipv4p_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_valid_res (valid_res),
      .rsp_address   (address)
   );

   assign rsp_tdata = {7'b0, address, valid_res};

endmodule

`default_nettype wire

// ===== design/ipv4p_checker.sv =====
// Port-level checks for the IPv4 dotted address parser, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module ipv4p_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // A result that is not taken stays with the same payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // An invalid text always reports a zero address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[32:1] == 32'h0)
      else $error("invalid result with non-zero address");

   // Padding bits of the result are zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:33] == 7'h0)
      else $error("result padding not zero");

   // No result is offered right after reset.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result offered straight after reset");

   // The queue is empty right after reset, so a request can be taken.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> req_tready)
      else $error("request channel not ready straight after reset");

endmodule

bind ipv4_dotted_address_parser ipv4p_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
